/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files of the history ring.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the reset is high.
`define HRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds while the reset is high.
`define HRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/hrc_pkg.sv */
// Shared types and constants of the history ring with cursor.
// Used by hrc_ctrl, hrc_out, the top level and the checker; depends on nothing.
package hrc_pkg;

   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_WORD_WIDTH = 32;

   localparam int CMD_WIDTH       = 3;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Register index, taken from paddr bit 2 (word addressed)
   localparam logic REG_SIZE_LIMIT = 1'b0;
   localparam logic REG_CYCLE_MODE = 1'b1;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH       = 3'd0,
      CMD_POP        = 3'd1,
      CMD_RESET_CUR  = 3'd2,
      CMD_NEXT       = 3'd3,
      CMD_PREV       = 3'd4,
      CMD_READ_FIRST = 3'd5,
      CMD_READ_LAST  = 3'd6,
      CMD_READ_CUR   = 3'd7
   } cmd_type;

   // Per-request status flags passed from control to the output stage
   typedef struct packed {
      logic word_valid;
      logic before_first;
   } status_type;

endpackage

/* hw/rtl/hrc_mem.sv */
// Entry store of the history ring: one write port, one registered read port.
// Depends on nothing but its parameters.
module hrc_mem #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_WIDTH-1:0]    rd_data
);

   logic [WORD_WIDTH-1:0] store_ff [DEPTH];
   logic [WORD_WIDTH-1:0] rd_data_ff;

   // Write the pushed word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, updated only while rd_en is set
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/hrc_ctrl.sv */
// Pointer state and command decode of the history ring.
// Drives the entry store addresses; uses hrc_pkg types.
module hrc_ctrl #(
   parameter int DEPTH      = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         issue,
   input  hrc_pkg::cmd_type             cmd,
   input  logic [WORD_WIDTH-1:0]        push_word,
   input  logic [$clog2(DEPTH+1)-1:0]   size_limit,
   input  logic                         cycle_mode,
   output logic                         wr_en,
   output logic [$clog2(DEPTH)-1:0]     wr_addr,
   output logic [WORD_WIDTH-1:0]        wr_data,
   output logic [$clog2(DEPTH)-1:0]     rd_addr,
   output hrc_pkg::status_type          status,
   output logic [$clog2(DEPTH+1)-1:0]   count_next
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;

   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] offset_ff, offset_in;
   logic          at_start_ff, at_start_in;

   logic [CW-1:0] limit;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] push_m1;
   logic [AW-1:0] slot1;
   logic [SW-1:0] rd_k;
   logic          nonempty;
   logic          at_last;
   logic          hit;

   // Ring slot of the k-th entry counted from the oldest
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [SW-1:0] k);
      logic [SW-1:0] sum;
      sum = {1'b0, base} + k;
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // Zero and values above the depth select the full depth
   assign limit = (size_limit == '0 || size_limit > CW'(DEPTH)) ? CW'(DEPTH) : size_limit;

   assign nonempty = (count_ff != '0);
   assign count_m1 = count_ff - CW'(1);
   assign at_last  = (({1'b0, offset_ff} + SW'(1)) >= SW'(count_ff));
   assign slot1    = slot_of(oldest_ff, SW'(1));

   // Decode the command into next pointer state and a read offset
   always_comb begin
      oldest_in   = oldest_ff;
      count_in    = count_ff;
      offset_in   = offset_ff;
      at_start_in = at_start_ff;
      hit         = 1'b0;
      rd_k        = '0;
      push_m1     = '0;
      unique case (cmd)
         hrc_pkg::CMD_PUSH: begin
            if (count_ff >= limit) begin
               oldest_in = slot1;
            end else begin
               count_in = count_ff + CW'(1);
            end
            push_m1     = count_in - CW'(1);
            at_start_in = 1'b0;
            offset_in   = push_m1[AW-1:0];
         end
         hrc_pkg::CMD_POP: begin
            if (nonempty) begin
               hit       = 1'b1;
               oldest_in = slot1;
               count_in  = count_m1;
               if (!at_start_ff && offset_ff != '0) begin
                  offset_in = offset_ff - AW'(1);
               end
               if (count_m1 == '0) begin
                  at_start_in = 1'b1;
                  offset_in   = '0;
               end
            end
         end
         hrc_pkg::CMD_RESET_CUR: begin
            at_start_in = 1'b1;
            offset_in   = '0;
         end
         hrc_pkg::CMD_NEXT: begin
            if (nonempty) begin
               if (at_start_ff) begin
                  at_start_in = 1'b0;
                  offset_in   = '0;
                  hit         = 1'b1;
               end else if (!at_last) begin
                  offset_in = offset_ff + AW'(1);
                  hit       = 1'b1;
               end else if (cycle_mode) begin
                  offset_in = '0;
                  hit       = 1'b1;
               end else begin
                  offset_in = count_m1[AW-1:0];
               end
            end
            rd_k = {1'b0, offset_in};
         end
         hrc_pkg::CMD_PREV: begin
            if (nonempty) begin
               if (at_start_ff || offset_ff == '0) begin
                  if (cycle_mode) begin
                     at_start_in = 1'b0;
                     offset_in   = count_m1[AW-1:0];
                     hit         = 1'b1;
                  end else if (at_start_ff) begin
                     at_start_in = 1'b0;
                     offset_in   = '0;
                  end
               end else begin
                  offset_in = offset_ff - AW'(1);
                  hit       = 1'b1;
               end
            end
            rd_k = {1'b0, offset_in};
         end
         hrc_pkg::CMD_READ_FIRST: begin
            hit = nonempty;
         end
         hrc_pkg::CMD_READ_LAST: begin
            hit  = nonempty;
            rd_k = SW'(count_m1);
         end
         hrc_pkg::CMD_READ_CUR: begin
            hit  = nonempty && !at_start_ff;
            rd_k = {1'b0, offset_ff};
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

   // Store addresses: push goes to the tail slot
   assign wr_en   = issue && (cmd == hrc_pkg::CMD_PUSH);
   assign wr_addr = slot_of(oldest_ff, SW'(count_ff));
   assign wr_data = push_word;
   assign rd_addr = slot_of(oldest_ff, rd_k);

   assign status.word_valid   = hit;
   assign status.before_first = at_start_in;
   assign count_next          = count_in;

   // Advance pointer state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff   <= '0;
         count_ff    <= '0;
         offset_ff   <= '0;
         at_start_ff <= 1'b1;
      end else if (issue) begin
         oldest_ff   <= oldest_in;
         count_ff    <= count_in;
         offset_ff   <= offset_in;
         at_start_ff <= at_start_in;
      end
   end

endmodule

/* hw/rtl/hrc_out.sv */
// Read-data stage and output register of the history ring.
// Joins store read data with request status; uses hrc_pkg types.
module hrc_out #(
   parameter int WORD_WIDTH = 32,
   parameter int CW         = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  issue,
   input  hrc_pkg::status_type   status_in,
   input  logic [CW-1:0]         count_in,
   input  logic [WORD_WIDTH-1:0] rd_data,
   output logic                  take,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [WORD_WIDTH-1:0] word_out,
   output hrc_pkg::status_type   status_out,
   output logic [CW-1:0]         count_out
);

   logic                  s2_valid_ff, s2_valid_in;
   hrc_pkg::status_type   s2_status_ff;
   logic [CW-1:0]         s2_count_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [WORD_WIDTH-1:0] out_word_ff;
   hrc_pkg::status_type   out_status_ff;
   logic [CW-1:0]         out_count_ff;
   logic                  s2_move;

   // Move the read stage forward when the output register frees up
   assign s2_move = s2_valid_ff && (!out_valid_ff || rsp_tready);
   assign take    = !s2_valid_ff || s2_move;

   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (issue) begin
         s2_valid_in = 1'b1;
      end else if (s2_move) begin
         s2_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s2_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payload; drop the word to zero when no entry was returned
   always_ff @(posedge clock) begin
      if (issue) begin
         s2_status_ff <= status_in;
         s2_count_ff  <= count_in;
      end
      if (s2_move) begin
         out_word_ff   <= s2_status_ff.word_valid ? rd_data : '0;
         out_status_ff <= s2_status_ff;
         out_count_ff  <= s2_count_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign word_out   = out_word_ff;
   assign status_out = out_status_ff;
   assign count_out  = out_count_ff;

endmodule

/* hw/rtl/history_ring_with_cursor_unit.sv */
// History ring with browse cursor: top level, configuration registers.
// Instantiates hrc_ctrl, hrc_mem and hrc_out; uses hrc_pkg.
//
// Usage:
//   Requests enter on the req_ stream: req_tuser carries the command, req_tdata the
//   word for a push. Every request yields exactly one result on the rsp_ stream:
//   rsp_tuser flags a returned entry, rsp_tdata carries the word, the entry count
//   after the request and the cursor start flag.
//   Results pass the read stage, then the output register. One request is taken
//   every cycle while the output does not stall: pointers update at acceptance and
//   the store read port delivers the entry the cycle after, so requests may follow directly.
//   When the receiver stalls, the result waits in the output register and one more
//   request is held in the read stage; req_tready then drops until rsp_tready rises.
//   Reset (synchronous) empties the ring, puts the cursor at the start position and
//   clears both registers; the entry store itself is not cleared.
//   The csr_ port holds size_limit at address 0 and cycle_mode at address 4; write
//   them only while no request is in flight.
module history_ring_with_cursor_unit #(
   parameter int DEPTH      = hrc_pkg::DEFAULT_DEPTH,
   parameter int WORD_WIDTH = hrc_pkg::DEFAULT_WORD_WIDTH
) (
   input  logic                                             clock,
   input  logic                                             reset,
   // req_tdata: push_word
   input  logic                                             req_tvalid,
   output logic                                             req_tready,
   input  logic [((WORD_WIDTH+7)/8)*8-1:0]                  req_tdata,
   // req_tuser: command
   input  logic [hrc_pkg::CMD_WIDTH-1:0]                    req_tuser,
   // rsp_tdata: word_out, entry_count, cursor_before_first
   output logic                                             rsp_tvalid,
   input  logic                                             rsp_tready,
   output logic [((WORD_WIDTH+$clog2(DEPTH+1)+1+7)/8)*8-1:0] rsp_tdata,
   // rsp_tuser: word_valid
   output logic                                             rsp_tuser,
   input  logic                                             csr_psel,
   input  logic                                             csr_penable,
   input  logic                                             csr_pwrite,
   input  logic [hrc_pkg::CSR_ADDR_WIDTH-1:0]               csr_paddr,
   input  logic [hrc_pkg::CSR_DATA_WIDTH-1:0]               csr_pwdata,
   output logic [hrc_pkg::CSR_DATA_WIDTH-1:0]               csr_prdata,
   output logic                                             csr_pready
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int OUT_W = ((WORD_WIDTH + CW + 1 + 7) / 8) * 8;
   localparam int PAD_W = OUT_W - WORD_WIDTH - CW - 1;

   logic [CW-1:0]         size_limit_ff;
   logic                  cycle_mode_ff;
   logic                  csr_wr;
   logic                  issue;
   logic                  take;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;
   logic [AW-1:0]         rd_addr;
   logic [WORD_WIDTH-1:0] rd_data;
   hrc_pkg::status_type   status;
   logic [CW-1:0]         count_next;
   logic [WORD_WIDTH-1:0] word_out;
   hrc_pkg::status_type   status_out;
   logic [CW-1:0]         count_out;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_limit_ff <= '0;
         cycle_mode_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            hrc_pkg::REG_SIZE_LIMIT: size_limit_ff <= csr_pwdata[CW-1:0];
            hrc_pkg::REG_CYCLE_MODE: cycle_mode_ff <= csr_pwdata[0];
            default:                 cycle_mode_ff <= cycle_mode_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         hrc_pkg::REG_SIZE_LIMIT: csr_prdata = hrc_pkg::CSR_DATA_WIDTH'(size_limit_ff);
         hrc_pkg::REG_CYCLE_MODE: csr_prdata = hrc_pkg::CSR_DATA_WIDTH'(cycle_mode_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   // Request handshake
   assign req_tready = take;
   assign issue      = req_tvalid && take;

   hrc_ctrl #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .cmd        (hrc_pkg::cmd_type'(req_tuser)),
      .push_word  (req_tdata[WORD_WIDTH-1:0]),
      .size_limit (size_limit_ff),
      .cycle_mode (cycle_mode_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .status     (status),
      .count_next (count_next)
   );

   hrc_mem #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hrc_out #(
      .WORD_WIDTH (WORD_WIDTH),
      .CW         (CW)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .issue      (issue),
      .status_in  (status),
      .count_in   (count_next),
      .rd_data    (rd_data),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .word_out   (word_out),
      .status_out (status_out),
      .count_out  (count_out)
   );

   // Pack the result fields, lowest first
   assign rsp_tdata = {{PAD_W{1'b0}}, status_out.before_first, count_out, word_out};
   assign rsp_tuser = status_out.word_valid;

endmodule

/* hw/rtl/hrc_checker.sv */
// Port-level checks of the history ring, bound to the top level.
// Depends on assert_macros.svh and hrc_pkg.
`include "assert_macros.svh"

module hrc_checker #(
   parameter int DEPTH      = hrc_pkg::DEFAULT_DEPTH,
   parameter int WORD_WIDTH = hrc_pkg::DEFAULT_WORD_WIDTH
) (
   input logic                                             clock,
   input logic                                             reset,
   input logic                                             req_tvalid,
   input logic                                             req_tready,
   input logic [((WORD_WIDTH+7)/8)*8-1:0]                  req_tdata,
   input logic [hrc_pkg::CMD_WIDTH-1:0]                    req_tuser,
   input logic                                             rsp_tvalid,
   input logic                                             rsp_tready,
   input logic [((WORD_WIDTH+$clog2(DEPTH+1)+1+7)/8)*8-1:0] rsp_tdata,
   input logic                                             rsp_tuser,
   input logic                                             csr_psel,
   input logic                                             csr_penable,
   input logic                                             csr_pwrite,
   input logic [hrc_pkg::CSR_ADDR_WIDTH-1:0]               csr_paddr,
   input logic [hrc_pkg::CSR_DATA_WIDTH-1:0]               csr_pwdata,
   input logic [hrc_pkg::CSR_DATA_WIDTH-1:0]               csr_prdata,
   input logic                                             csr_pready
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [WORD_WIDTH-1:0] word_f;
   logic [CW-1:0]         count_f;
   logic                  start_f;

   assign word_f  = rsp_tdata[WORD_WIDTH-1:0];
   assign count_f = rsp_tdata[WORD_WIDTH +: CW];
   assign start_f = rsp_tdata[WORD_WIDTH + CW];

   // A stalled result holds
   `HRC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // A result without an entry carries a zero word
   `HRC_ASSERT(a_word_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> word_f == '0, "word set without entry")

   // The count never exceeds the depth
   `HRC_ASSERT(a_count_max, clock, reset, rsp_tvalid |-> count_f <= FULL_COUNT, "entry count above depth")

   // An empty ring keeps the cursor at the start position
   `HRC_ASSERT(a_empty_start, clock, reset, rsp_tvalid && count_f == '0 |-> start_f, "empty ring with cursor on entry")

   // Reset leaves no result pending
   `HRC_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "result pending after reset")

endmodule

bind history_ring_with_cursor_unit hrc_checker #(
   .DEPTH      (DEPTH),
   .WORD_WIDTH (WORD_WIDTH)
) u_hrc_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench of history_ring_with_cursor_unit: directed cursor and
// overwrite cases, a long output stall, then random request phases per setting.
// Depends on hrc_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_top;

   localparam int RING_DEPTH      = hrc_pkg::DEFAULT_DEPTH;
   localparam int WORD_W          = hrc_pkg::DEFAULT_WORD_WIDTH;
   localparam int REQ_DATA_W      = ((WORD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W      = ((WORD_W + $clog2(RING_DEPTH + 1) + 1 + 7) / 8) * 8;
   localparam int CLK_HALF        = 2;
   localparam int RESET_CYCLES    = 10;
   localparam int IDLE_SETTLE     = 4;
   localparam int DRAIN_CYCLES    = 10;
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int RANDOM_ITEMS    = 1800;
   localparam int SEGMENT_ITEMS   = 30;
   localparam int NUM_PHASES      = 8;

   // Expected response of one request
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              valid;
      logic [4:0]        count;
      logic              home;
   } ring_result_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [REQ_DATA_W-1:0]              req_tdata = '0;
   logic [hrc_pkg::CMD_WIDTH-1:0]      req_tuser = hrc_pkg::CMD_PUSH;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]              rsp_tdata;
   logic                               rsp_tuser;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [hrc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [hrc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [hrc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   // Predictor state of the ring
   logic [WORD_W-1:0] ring_store [RING_DEPTH];
   logic [3:0]        head_slot   = '0;
   int unsigned       fill        = 0;
   int unsigned       cursor_pos  = 0;
   bit                cursor_home = 1'b1;
   logic [4:0]        limit_reg   = '0;
   bit                wrap_reg    = 1'b0;

   ring_result_type pending_results [$];
   int              fail_count   = 0;
   int              burst_left   = 0;
   int              stall_cycles = 0;
   bit              hold_request = 1'b0;
   int              hold_left    = 0;
   int              pattern_left = 0;
   int              stall_mode   = 0;

   history_ring_with_cursor_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   function automatic logic [3:0] ring_slot(int unsigned k);
      return 4'((head_slot + k) % RING_DEPTH);
   endfunction

   // Advance the ring and cursor for one request, return its response
   function automatic ring_result_type apply_request(hrc_pkg::cmd_type cmd,
                                                     logic [WORD_W-1:0] word);
      ring_result_type r;
      int unsigned     cap;
      r   = '0;
      cap = (limit_reg == 0 || limit_reg > RING_DEPTH) ? RING_DEPTH : limit_reg;
      case (cmd)
         hrc_pkg::CMD_PUSH: begin
            ring_store[ring_slot(fill)] = word;
            if (fill >= cap) head_slot = ring_slot(1);
            else fill++;
            cursor_home = 1'b0;
            cursor_pos  = fill - 1;
         end
         hrc_pkg::CMD_POP: begin
            if (fill != 0) begin
               r.word    = ring_store[ring_slot(0)];
               r.valid   = 1'b1;
               head_slot = ring_slot(1);
               fill--;
               if (!cursor_home && cursor_pos != 0) cursor_pos--;
               if (fill == 0) begin
                  cursor_home = 1'b1;
                  cursor_pos  = 0;
               end
            end
         end
         hrc_pkg::CMD_RESET_CUR: begin
            cursor_home = 1'b1;
            cursor_pos  = 0;
         end
         hrc_pkg::CMD_NEXT: begin
            if (fill != 0) begin
               if (cursor_home) begin
                  cursor_home = 1'b0;
                  cursor_pos  = 0;
                  r.valid     = 1'b1;
               end else if (cursor_pos + 1 < fill) begin
                  cursor_pos++;
                  r.valid = 1'b1;
               end else if (wrap_reg) begin
                  cursor_pos = 0;
                  r.valid    = 1'b1;
               end else begin
                  cursor_pos = fill - 1;
               end
               if (r.valid) r.word = ring_store[ring_slot(cursor_pos)];
            end
         end
         hrc_pkg::CMD_PREV: begin
            if (fill != 0) begin
               if (cursor_home || cursor_pos == 0) begin
                  if (wrap_reg) begin
                     cursor_home = 1'b0;
                     cursor_pos  = fill - 1;
                     r.valid     = 1'b1;
                  end else if (cursor_home) begin
                     cursor_home = 1'b0;
                     cursor_pos  = 0;
                  end
               end else begin
                  cursor_pos--;
                  r.valid = 1'b1;
               end
               if (r.valid) r.word = ring_store[ring_slot(cursor_pos)];
            end
         end
         hrc_pkg::CMD_READ_FIRST: begin
            if (fill != 0) begin
               r.word  = ring_store[ring_slot(0)];
               r.valid = 1'b1;
            end
         end
         hrc_pkg::CMD_READ_LAST: begin
            if (fill != 0) begin
               r.word  = ring_store[ring_slot(fill - 1)];
               r.valid = 1'b1;
            end
         end
         default: begin
            if (fill != 0 && !cursor_home) begin
               r.word  = ring_store[ring_slot(cursor_pos)];
               r.valid = 1'b1;
            end
         end
      endcase
      r.count = 5'(fill);
      r.home  = cursor_home;
      return r;
   endfunction

   // Track register writes and accepted requests, check each response
   always @(posedge clock) begin
      ring_result_type exp_rsp;
      if (!reset) begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            // paddr bit 2 selects the register
            if (csr_paddr[2] == hrc_pkg::REG_SIZE_LIMIT) limit_reg = csr_pwdata[4:0];
            else wrap_reg = csr_pwdata[0];
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(apply_request(hrc_pkg::cmd_type'(req_tuser),
                                                    req_tdata[WORD_W-1:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               exp_rsp = pending_results.pop_front();
               if (rsp_tdata[WORD_W-1:0] !== exp_rsp.word) begin
                  $error("word_out: expected %h, actual %h", exp_rsp.word,
                         rsp_tdata[WORD_W-1:0]);
                  fail_count++;
               end
               if (rsp_tuser !== exp_rsp.valid) begin
                  $error("word_valid: expected %0d, actual %0d", exp_rsp.valid, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[WORD_W+4:WORD_W] !== exp_rsp.count) begin
                  $error("entry_count: expected %0d, actual %0d", exp_rsp.count,
                         rsp_tdata[WORD_W+4:WORD_W]);
                  fail_count++;
               end
               if (rsp_tdata[WORD_W+5] !== exp_rsp.home) begin
                  $error("cursor_before_first: expected %0d, actual %0d", exp_rsp.home,
                         rsp_tdata[WORD_W+5]);
                  fail_count++;
               end
            end
         end
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Drive rsp_tready from a changing stall pattern, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (pattern_left == 0) begin
         stall_mode   = $urandom_range(0, 3);
         pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= pattern_left[1];
         endcase
      end
   end

   function automatic logic [WORD_W-1:0] rand_word();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return WORD_W'($urandom);
   endfunction

   // Offer one request, in bursts with random gaps, and hold until accepted
   task automatic send_request(hrc_pkg::cmd_type cmd, logic [WORD_W-1:0] word);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'(word);
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every outstanding response has arrived
   task automatic wait_until_idle(int settle);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write a register over the APB port, then read it back
   task automatic csr_write(logic reg_sel, logic [hrc_pkg::CSR_DATA_WIDTH-1:0] value);
      wait_until_idle(IDLE_SETTLE);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         $error("csr readback: expected %h, actual %h", value, csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_registers(int limit, int wrap);
      csr_write(hrc_pkg::REG_SIZE_LIMIT, hrc_pkg::CSR_DATA_WIDTH'(limit));
      csr_write(hrc_pkg::REG_CYCLE_MODE, hrc_pkg::CSR_DATA_WIDTH'(wrap));
   endtask

   // Every command but push and cursor reset on an empty ring answers no entry
   task automatic test_empty_queue();
      send_request(hrc_pkg::CMD_POP, rand_word());
      send_request(hrc_pkg::CMD_NEXT, rand_word());
      send_request(hrc_pkg::CMD_PREV, rand_word());
      send_request(hrc_pkg::CMD_READ_FIRST, rand_word());
      send_request(hrc_pkg::CMD_READ_LAST, rand_word());
      send_request(hrc_pkg::CMD_READ_CUR, rand_word());
   endtask

   // Overwrite at the limit and stop at both ends in linear mode
   task automatic test_cursor_linear();
      set_registers(3, 0);
      send_request(hrc_pkg::CMD_PUSH, 32'h0000_0000);
      send_request(hrc_pkg::CMD_PUSH, 32'hFFFF_FFFF);
      send_request(hrc_pkg::CMD_PUSH, 32'hA5A5_A5A5);
      send_request(hrc_pkg::CMD_PUSH, 32'h5A5A_5A5A);
      send_request(hrc_pkg::CMD_READ_FIRST, rand_word());
      send_request(hrc_pkg::CMD_READ_LAST, rand_word());
      send_request(hrc_pkg::CMD_NEXT, rand_word());
      send_request(hrc_pkg::CMD_PREV, rand_word());
      send_request(hrc_pkg::CMD_PREV, rand_word());
      send_request(hrc_pkg::CMD_PREV, rand_word());
      send_request(hrc_pkg::CMD_RESET_CUR, rand_word());
      send_request(hrc_pkg::CMD_PREV, rand_word());
      send_request(hrc_pkg::CMD_READ_CUR, rand_word());
   endtask

   // Wrap at both ends in cycle mode, pop the cursor entry, empty the ring
   task automatic test_cursor_cycle();
      csr_write(hrc_pkg::REG_CYCLE_MODE, hrc_pkg::CSR_DATA_WIDTH'(1));
      send_request(hrc_pkg::CMD_PREV, rand_word());
      send_request(hrc_pkg::CMD_NEXT, rand_word());
      send_request(hrc_pkg::CMD_RESET_CUR, rand_word());
      send_request(hrc_pkg::CMD_PREV, rand_word());
      send_request(hrc_pkg::CMD_NEXT, rand_word());
      send_request(hrc_pkg::CMD_POP, rand_word());
      send_request(hrc_pkg::CMD_POP, rand_word());
      send_request(hrc_pkg::CMD_POP, rand_word());
   endtask

   // Lower the limit below the count: pushes overwrite, count holds
   task automatic test_limit_lowered();
      csr_write(hrc_pkg::REG_SIZE_LIMIT, hrc_pkg::CSR_DATA_WIDTH'(0));
      repeat (3) send_request(hrc_pkg::CMD_PUSH, rand_word());
      csr_write(hrc_pkg::REG_SIZE_LIMIT, hrc_pkg::CSR_DATA_WIDTH'(1));
      send_request(hrc_pkg::CMD_PUSH, rand_word());
   endtask

   // Hold off the receiver while requests keep coming, so the input stalls
   task automatic test_input_stall();
      wait_until_idle(IDLE_SETTLE);
      burst_left   = 1000;
      hold_request = 1'b1;
      repeat (40)
         send_request(($urandom_range(0, 1) != 0) ? hrc_pkg::CMD_PUSH
                      : hrc_pkg::cmd_type'($urandom_range(1, 7)), rand_word());
      burst_left = 0;
   endtask

   // Random requests over several settings, with varying push density
   task automatic test_random_phases();
      int limits [NUM_PHASES] = '{0, 16, 1, 31, 2, 17, 8, 0};
      int wraps  [NUM_PHASES] = '{0, 1, 0, 1, 1, 0, 0, 1};
      int push_pct;
      int limit;
      int wrap;
      for (int p = 0; p < NUM_PHASES; p++) begin
         limit = limits[p];
         wrap  = wraps[p];
         // last phase takes a random setting
         if (p == NUM_PHASES - 1) begin
            limit = $urandom_range(0, 31);
            wrap  = $urandom_range(0, 1);
         end
         set_registers(limit, wrap);
         push_pct = 50;
         for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++) begin
            if (i % SEGMENT_ITEMS == 0) begin
               case ($urandom_range(0, 3))
                  0:       push_pct = 15;
                  1:       push_pct = 35;
                  2:       push_pct = 55;
                  default: push_pct = 80;
               endcase
            end
            send_request(($urandom_range(0, 99) < push_pct) ? hrc_pkg::CMD_PUSH
                         : hrc_pkg::cmd_type'($urandom_range(1, 7)), rand_word());
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_cursor_linear();
      test_cursor_cycle();
      test_limit_lowered();
      test_input_stall();
      test_random_phases();
      wait_until_idle(DRAIN_CYCLES);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/hrc_pkg.sv
hw/rtl/hrc_mem.sv
hw/rtl/hrc_ctrl.sv
hw/rtl/hrc_out.sv
hw/rtl/history_ring_with_cursor_unit.sv
hw/rtl/hrc_checker.sv
sim/tb_top.sv
